[src/uoac_pkg.sv]
`timescale 1ns / 1ps

package uoac_pkg;

   localparam int COUNT_W   = 20;
   localparam int TIMEOUT_W = 16;
   localparam int LIMIT_W   = 20;
   localparam int DUTY_W    = 10;
   localparam int WIDTH_W   = 16;
   localparam int DIST_W    = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 20;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 72;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_TICKS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_TICKS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_DUTY   = 3'd6;

   // result tdata field positions
   localparam int RSP_TRIG_LSB  = 0;
   localparam int RSP_A_REV_LSB = 1;
   localparam int RSP_A_FWD_LSB = 11;
   localparam int RSP_B_REV_LSB = 21;
   localparam int RSP_B_FWD_LSB = 31;
   localparam int RSP_MODE_LSB  = 41;
   localparam int RSP_DONE_LSB  = 43;
   localparam int RSP_FAIL_LSB  = 44;
   localparam int RSP_DIST_LSB  = 45;

   typedef enum logic [2:0] {
      PH_TRIG_LOW  = 3'd0,
      PH_TRIG_HIGH = 3'd1,
      PH_WAIT_RISE = 3'd2,
      PH_MEASURE   = 3'd3,
      PH_DRIVE     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      MODE_BRAKE   = 2'd0,
      MODE_FORWARD = 2'd1,
      MODE_LEFT    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] echo_timeout_ticks;
      logic [LIMIT_W-1:0]   near_limit;
      logic [LIMIT_W-1:0]   turn_limit;
      logic [LIMIT_W-1:0]   far_limit;
      logic [COUNT_W-1:0]   turn_ticks;
      logic [COUNT_W-1:0]   forward_ticks;
      logic [DUTY_W-1:0]    drive_duty;
   } cfg_type;

   typedef struct packed {
      phase_type           phase;
      logic [COUNT_W-1:0]  phase_count;
      logic [WIDTH_W-1:0]  echo_width;
      mode_type            motion_state;
      logic [DIST_W-1:0]   last_distance;
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_milli_cm;
      logic              range_failed;
      logic              range_done;
      logic [1:0]        motion_mode;
      logic [DUTY_W-1:0] wheel_b_forward;
      logic [DUTY_W-1:0] wheel_b_reverse;
      logic [DUTY_W-1:0] wheel_a_forward;
      logic [DUTY_W-1:0] wheel_a_reverse;
      logic              trigger_out;
   } result_type;

endpackage

[src/uoac_step.sv]
`timescale 1ns / 1ps

module uoac_step #(
   parameter int TRIG_LOW_TICKS  = 2,
   parameter int TRIG_HIGH_TICKS = 10,
   parameter int CM_SCALE        = 17
) (
   input  uoac_pkg::state_type  state_cur,
   input  uoac_pkg::cfg_type    cfg,
   input  logic                 echo_level,
   output uoac_pkg::state_type  state_nxt,
   output uoac_pkg::result_type result
);
   import uoac_pkg::*;

   localparam int SCALE_W = $clog2(CM_SCALE + 1);
   localparam int PROD_W  = WIDTH_W + SCALE_W;
   localparam int EXT_W   = (PROD_W > DIST_W) ? PROD_W : DIST_W;

   logic [COUNT_W-1:0] count_inc;
   logic               wait_expired;
   logic [WIDTH_W-1:0] width_new;
   logic [PROD_W-1:0]  prod;
   logic [EXT_W-1:0]   prod_ext;
   logic [DIST_W-1:0]  dist_new;
   logic [COUNT_W-1:0] drive_dur;
   logic               done;
   logic               failed;
   mode_type           mode_out;

   assign count_inc    = state_cur.phase_count + COUNT_W'(1);
   assign wait_expired = count_inc > COUNT_W'(cfg.echo_timeout_ticks);
   assign width_new    = state_cur.phase_count[WIDTH_W-1:0];
   assign prod         = PROD_W'(width_new) * PROD_W'(CM_SCALE);
   assign prod_ext     = EXT_W'(prod);
   assign dist_new     = (prod_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : prod_ext[DIST_W-1:0];
   assign drive_dur    = (state_cur.motion_state == MODE_LEFT) ? cfg.turn_ticks
                                                               : cfg.forward_ticks;

   always_comb begin
      state_nxt = state_cur;
      done      = 1'b0;
      failed    = 1'b0;
      unique case (state_cur.phase)
         PH_TRIG_HIGH: begin
            state_nxt.phase_count = count_inc;
            if (count_inc >= COUNT_W'(TRIG_HIGH_TICKS)) begin
               state_nxt.phase       = PH_WAIT_RISE;
               state_nxt.phase_count = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (echo_level) begin
               state_nxt.phase       = PH_MEASURE;
               state_nxt.phase_count = '0;
            end else begin
               state_nxt.phase_count = count_inc;
               if (wait_expired) begin
                  failed                = 1'b1;
                  state_nxt.phase       = PH_TRIG_LOW;
                  state_nxt.phase_count = '0;
               end
            end
         end
         PH_MEASURE: begin
            if (!echo_level) begin
               done                    = 1'b1;
               state_nxt.echo_width    = width_new;
               state_nxt.last_distance = dist_new;
               state_nxt.phase_count   = '0;
               state_nxt.phase         = PH_TRIG_LOW;
               if (dist_new > DIST_W'(cfg.near_limit)
                   && dist_new < DIST_W'(cfg.turn_limit)) begin
                  if (cfg.turn_ticks != '0) begin
                     state_nxt.motion_state = MODE_LEFT;
                     state_nxt.phase        = PH_DRIVE;
                  end
               end else if (dist_new > DIST_W'(cfg.turn_limit)
                            && dist_new < DIST_W'(cfg.far_limit)) begin
                  if (cfg.forward_ticks != '0) begin
                     state_nxt.motion_state = MODE_FORWARD;
                     state_nxt.phase        = PH_DRIVE;
                  end
               end else begin
                  state_nxt.motion_state = MODE_BRAKE;
               end
            end else begin
               state_nxt.phase_count = count_inc;
               if (wait_expired) begin
                  failed                = 1'b1;
                  state_nxt.phase       = PH_TRIG_LOW;
                  state_nxt.phase_count = '0;
               end
            end
         end
         PH_DRIVE: begin
            state_nxt.phase_count = count_inc;
            if (count_inc >= drive_dur) begin
               state_nxt.phase       = PH_TRIG_LOW;
               state_nxt.phase_count = '0;
            end
         end
         default: begin
            state_nxt.phase       = PH_TRIG_LOW;
            state_nxt.phase_count = count_inc;
            if (count_inc >= COUNT_W'(TRIG_LOW_TICKS)) begin
               state_nxt.phase       = PH_TRIG_HIGH;
               state_nxt.phase_count = '0;
            end
         end
      endcase
   end

   assign mode_out = state_nxt.motion_state;

   always_comb begin
      result                   = '0;
      result.trigger_out       = (state_cur.phase == PH_TRIG_HIGH);
      result.wheel_a_reverse   = '0;
      result.wheel_a_forward   = (mode_out == MODE_FORWARD) ? cfg.drive_duty : '0;
      result.wheel_b_reverse   = '0;
      result.wheel_b_forward   = (mode_out == MODE_FORWARD || mode_out == MODE_LEFT)
                                 ? cfg.drive_duty : '0;
      result.motion_mode       = mode_out;
      result.range_done        = done;
      result.range_failed      = failed;
      result.distance_milli_cm = state_nxt.last_distance;
   end

endmodule

[src/ultrasonic_obstacle_avoid_ctrl_top.sv]
`timescale 1ns / 1ps

// channel   direction  ports                       tdata fields (lsb first)
// -------   ---------  --------------------------  -----------------------------------
// req       in         req_tvalid/tready/tdata[7:0]  echo_level
// rsp       out        rsp_tvalid/tready/tdata[71:0] see rsp_tdata port
// csr       in         csr_we/index[2:0]/wdata[19:0] register write, no read-back
//
// One request gives one response; a new request is taken every cycle unless the response stalls.
// The step logic sits between the state and the output register, so each response is registered.
// Reset (synchronous) loads the register defaults and starts at the trigger-low phase.
// A stalled response holds the request side only while the output register is full and not taken.

module ultrasonic_obstacle_avoid_ctrl_top #(
   parameter int TRIG_LOW_TICKS  = 2,
   parameter int TRIG_HIGH_TICKS = 10,
   parameter int CM_SCALE        = 17
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [0] echo_level, [7:1] zero
   input  logic [uoac_pkg::REQ_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] trigger_out, [10:1] wheel_a_reverse, [20:11] wheel_a_forward,
   // [30:21] wheel_b_reverse, [40:31] wheel_b_forward, [42:41] motion_mode,
   // [43] range_done, [44] range_failed, [65:45] distance_milli_cm, [71:66] zero
   output logic [uoac_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           csr_we,
   input  logic [uoac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uoac_pkg::CSR_W-1:0]     csr_wdata
);
   import uoac_pkg::*;

   cfg_type          cfg_ff;
   state_type        state_ff;
   state_type        state_in;
   result_type       result;
   logic             rsp_tvalid_ff;
   logic [RSP_W-1:0] rsp_tdata_ff;
   logic             req_accept;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   uoac_step #(
      .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
      .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
      .CM_SCALE        (CM_SCALE)
   ) u_step (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .echo_level (req_tdata[0]),
      .state_nxt  (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_timeout_ticks <= TIMEOUT_W'(5000);
         cfg_ff.near_limit         <= LIMIT_W'(4000);
         cfg_ff.turn_limit         <= LIMIT_W'(30000);
         cfg_ff.far_limit          <= LIMIT_W'(450000);
         cfg_ff.turn_ticks         <= COUNT_W'(300000);
         cfg_ff.forward_ticks      <= COUNT_W'(500000);
         cfg_ff.drive_duty         <= DUTY_W'(500);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ECHO_TIMEOUT: cfg_ff.echo_timeout_ticks <= csr_wdata[TIMEOUT_W-1:0];
            CSR_NEAR_LIMIT:   cfg_ff.near_limit         <= csr_wdata[LIMIT_W-1:0];
            CSR_TURN_LIMIT:   cfg_ff.turn_limit         <= csr_wdata[LIMIT_W-1:0];
            CSR_FAR_LIMIT:    cfg_ff.far_limit          <= csr_wdata[LIMIT_W-1:0];
            CSR_TURN_TICKS:   cfg_ff.turn_ticks         <= csr_wdata[COUNT_W-1:0];
            CSR_FWD_TICKS:    cfg_ff.forward_ticks      <= csr_wdata[COUNT_W-1:0];
            CSR_DRIVE_DUTY:   cfg_ff.drive_duty         <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_TRIG_LOW;
         state_ff.phase_count   <= '0;
         state_ff.echo_width    <= '0;
         state_ff.motion_state  <= MODE_BRAKE;
         state_ff.last_distance <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // load the result on each accepted transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= RSP_W'(result);
      end
   end

endmodule

[src/uoac_checker.sv]
`timescale 1ns / 1ps

module uoac_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [uoac_pkg::RSP_W-1:0] rsp_tdata
);
   import uoac_pkg::*;

   logic [1:0]        mode;
   logic [DUTY_W-1:0] a_fwd;

   assign mode  = rsp_tdata[RSP_MODE_LSB +: 2];
   assign a_fwd = rsp_tdata[RSP_A_FWD_LSB +: DUTY_W];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_reverse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_A_REV_LSB +: DUTY_W] == '0
                     && rsp_tdata[RSP_B_REV_LSB +: DUTY_W] == '0)
      else $error("reverse channel driven");

   a_fwd_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode != MODE_FORWARD |-> a_fwd == '0)
      else $error("wheel a forward driven outside forward mode");

   a_rate: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

endmodule

bind ultrasonic_obstacle_avoid_ctrl_top uoac_checker u_uoac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/ultrasonic_obstacle_avoid_ctrl_top_test.sv]
`timescale 1ns / 1ps

module ultrasonic_obstacle_avoid_ctrl_top_test;

   import uoac_pkg::*;

   localparam int TRIG_LOW_TICKS  = 2;
   localparam int TRIG_HIGH_TICKS = 10;
   localparam int CM_SCALE        = 17;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 200000;

   localparam cfg_type CFG_RESET = '{
      echo_timeout_ticks: 16'd5000,
      near_limit:         20'd4000,
      turn_limit:         20'd30000,
      far_limit:          20'd450000,
      turn_ticks:         20'd300000,
      forward_ticks:      20'd500000,
      drive_duty:         10'd500
   };

   typedef struct packed {
      logic              echo;
      logic              typed;
      logic              trig;
      logic              done;
      logic [DIST_W-1:0] distance;
   } directed_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   // ranging predictor state
   phase_type          rng_phase = PH_TRIG_LOW;
   logic [COUNT_W-1:0] rng_count = '0;
   logic [WIDTH_W-1:0] rng_width = '0;
   mode_type           rng_mode  = MODE_BRAKE;
   logic [DIST_W-1:0]  rng_dist  = '0;
   cfg_type            rng_cfg   = CFG_RESET;

   result_type pending_results[$];
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   bit         idle_enable    = 1'b1;
   bit         hold_request   = 1'b0;
   int         hold_left      = 0;
   int         noise_pct      = 8;
   int         rise_delay     = 0;
   int         width_goal     = 0;

   directed_row_type directed_rows [22] = '{
      '{1'b0, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 21'd0},
      '{1'b0, 1'b1, 1'b0, 1'b1, 21'd51},
      '{1'b1, 1'b1, 1'b0, 1'b0, 21'd51},
      '{1'b0, 1'b1, 1'b0, 1'b0, 21'd51},
      '{1'b1, 1'b0, 1'b0, 1'b0, 21'd0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 21'd0}
   };

   ultrasonic_obstacle_avoid_ctrl_top #(
      .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
      .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
      .CM_SCALE        (CM_SCALE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic begin_motion(input mode_type mode, input logic [COUNT_W-1:0] dur);
      if (dur == '0) begin
         rng_phase = PH_TRIG_LOW;
      end else begin
         rng_mode  = mode;
         rng_phase = PH_DRIVE;
      end
      rng_count = '0;
   endtask

   task automatic advance_ranging(input logic echo, output result_type res);
      logic               trig;
      logic               done;
      logic               failed;
      logic [31:0]        product;
      logic [COUNT_W-1:0] dur;
      trig   = (rng_phase == PH_TRIG_HIGH);
      done   = 1'b0;
      failed = 1'b0;
      case (rng_phase)
         PH_TRIG_HIGH: begin
            rng_count++;
            if (rng_count >= TRIG_HIGH_TICKS) begin
               rng_phase = PH_WAIT_RISE;
               rng_count = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (echo) begin
               rng_phase = PH_MEASURE;
               rng_count = '0;
            end else begin
               rng_count++;
               if (rng_count > rng_cfg.echo_timeout_ticks) begin
                  failed    = 1'b1;
                  rng_phase = PH_TRIG_LOW;
                  rng_count = '0;
               end
            end
         end
         PH_MEASURE: begin
            if (!echo) begin
               rng_width = rng_count[WIDTH_W-1:0];
               product   = rng_width * CM_SCALE;
               rng_dist  = (product > DIST_MAX) ? DIST_MAX : product[DIST_W-1:0];
               done      = 1'b1;
               if (rng_dist > rng_cfg.near_limit && rng_dist < rng_cfg.turn_limit) begin
                  begin_motion(MODE_LEFT, rng_cfg.turn_ticks);
               end else if (rng_dist > rng_cfg.turn_limit && rng_dist < rng_cfg.far_limit) begin
                  begin_motion(MODE_FORWARD, rng_cfg.forward_ticks);
               end else begin
                  rng_mode  = MODE_BRAKE;
                  rng_phase = PH_TRIG_LOW;
                  rng_count = '0;
               end
            end else begin
               rng_count++;
               if (rng_count > rng_cfg.echo_timeout_ticks) begin
                  failed    = 1'b1;
                  rng_phase = PH_TRIG_LOW;
                  rng_count = '0;
               end
            end
         end
         PH_DRIVE: begin
            dur = (rng_mode == MODE_LEFT) ? rng_cfg.turn_ticks : rng_cfg.forward_ticks;
            rng_count++;
            if (rng_count >= dur) begin
               rng_phase = PH_TRIG_LOW;
               rng_count = '0;
            end
         end
         default: begin
            rng_phase = PH_TRIG_LOW;
            rng_count++;
            if (rng_count >= TRIG_LOW_TICKS) begin
               rng_phase = PH_TRIG_HIGH;
               rng_count = '0;
            end
         end
      endcase
      res                   = '0;
      res.trigger_out       = trig;
      res.wheel_a_forward   = (rng_mode == MODE_FORWARD) ? rng_cfg.drive_duty : '0;
      res.wheel_b_forward   = (rng_mode == MODE_FORWARD || rng_mode == MODE_LEFT) ?
                              rng_cfg.drive_duty : '0;
      res.motion_mode       = rng_mode;
      res.range_done        = done;
      res.range_failed      = failed;
      res.distance_milli_cm = rng_dist;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic send_item(input logic echo, input logic typed, input result_type typed_res);
      result_type predicted;
      if (idle_enable && $urandom_range(99) < 5) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-1){1'b0}}, echo};
      do @(posedge clock); while (!req_tready);
      advance_ranging(echo, predicted);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   function automatic logic pick_echo();
      if ($urandom_range(99) < noise_pct) return logic'($urandom_range(1));
      case (rng_phase)
         PH_WAIT_RISE: return rng_count >= rise_delay;
         PH_MEASURE:   return rng_count < width_goal;
         default:      return logic'($urandom_range(1));
      endcase
   endfunction

   task automatic run_random(input int count);
      int tmo;
      int base;
      for (int i = 0; i < count; i++) begin
         if (rng_phase == PH_TRIG_HIGH) begin
            tmo        = rng_cfg.echo_timeout_ticks;
            rise_delay = $urandom_range(0, 4);
            if (tmo <= 300 && $urandom_range(99) < 8) rise_delay = tmo + 1;
            case ($urandom_range(3))
               0:       base = $urandom_range(0, 40);
               1:       base = rng_cfg.near_limit / CM_SCALE;
               2:       base = rng_cfg.turn_limit / CM_SCALE;
               default: base = rng_cfg.far_limit / CM_SCALE;
            endcase
            width_goal = base + int'($urandom_range(0, 2)) - 1;
            if (width_goal < 0) width_goal = 0;
            if (width_goal > 300) width_goal = $urandom_range(0, 300);
            if (width_goal > tmo) width_goal = tmo;
            if (tmo <= 300 && $urandom_range(99) < 8) width_goal = tmo + 1;
         end
         send_item(pick_echo(), 1'b0, '0);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input cfg_type c);
      write_reg(CSR_ECHO_TIMEOUT, {4'($urandom), c.echo_timeout_ticks});
      write_reg(CSR_NEAR_LIMIT, c.near_limit);
      write_reg(CSR_TURN_LIMIT, c.turn_limit);
      write_reg(CSR_FAR_LIMIT, c.far_limit);
      write_reg(CSR_TURN_TICKS, c.turn_ticks);
      write_reg(CSR_FWD_TICKS, c.forward_ticks);
      write_reg(CSR_DRIVE_DUTY, {10'($urandom), c.drive_duty});
      csr_we  <= 1'b0;
      rng_cfg = c;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         if (pending_results.size() == 0) begin
            $display("%0t unexpected transaction: expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("trigger_out", want.trigger_out, got.trigger_out);
            check_field("wheel_a_reverse", want.wheel_a_reverse, got.wheel_a_reverse);
            check_field("wheel_a_forward", want.wheel_a_forward, got.wheel_a_forward);
            check_field("wheel_b_reverse", want.wheel_b_reverse, got.wheel_b_reverse);
            check_field("wheel_b_forward", want.wheel_b_forward, got.wheel_b_forward);
            check_field("motion_mode", want.motion_mode, got.motion_mode);
            check_field("range_done", want.range_done, got.range_done);
            check_field("range_failed", want.range_failed, got.range_failed);
            check_field("distance_milli_cm", want.distance_milli_cm, got.distance_milli_cm);
            check_field("padding", '0, rsp_tdata[RSP_W-1:$bits(result_type)]);
         end
      end
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_enable && $urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** ultrasonic_obstacle_avoid_ctrl_top: FAILED **");
         $finish;
      end
   end

   initial begin
      cfg_type    c;
      result_type typed_res;
      int         guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_res                   = '0;
         typed_res.trigger_out       = directed_rows[i].trig;
         typed_res.range_done        = directed_rows[i].done;
         typed_res.distance_milli_cm = directed_rows[i].distance;
         send_item(directed_rows[i].echo, directed_rows[i].typed, typed_res);
      end
      drain();

      c.echo_timeout_ticks = 16'd40;
      c.near_limit         = 20'd51;
      c.turn_limit         = 20'd170;
      c.far_limit          = 20'd510;
      c.turn_ticks         = 20'd8;
      c.forward_ticks      = 20'd12;
      c.drive_duty         = 10'd1023;
      set_config(c);
      run_random(40);
      hold_request = 1'b1;
      run_random(110);
      drain();

      // zero timeout and zero drive duty
      c.echo_timeout_ticks = '0;
      c.drive_duty         = '0;
      set_config(c);
      run_random(60);
      drain();

      idle_enable          = 1'b0;
      c.echo_timeout_ticks = 16'd60;
      c.near_limit         = '0;
      c.turn_limit         = '0;
      c.far_limit          = '1;
      c.turn_ticks         = 20'd3;
      c.forward_ticks      = 20'd5;
      c.drive_duty         = 10'd341;
      set_config(c);
      run_random(80);
      drain();
      idle_enable = 1'b1;

      c.near_limit = '1;
      c.turn_limit = '1;
      c.drive_duty = 10'd682;
      set_config(c);
      run_random(40);
      drain();

      c.near_limit = '0;
      c.turn_limit = '0;
      c.far_limit  = '0;
      set_config(c);
      run_random(20);
      drain();

      // zero drive durations
      c.echo_timeout_ticks = 16'd40;
      c.near_limit         = 20'd51;
      c.turn_limit         = 20'd170;
      c.far_limit          = 20'd510;
      c.turn_ticks         = '0;
      c.forward_ticks      = '0;
      c.drive_duty         = 10'd1023;
      set_config(c);
      run_random(80);
      drain();

      // lower the drive duration while a drive is under way
      c.turn_ticks    = '1;
      c.forward_ticks = '1;
      set_config(c);
      guard = 0;
      while (!(rng_phase == PH_DRIVE && rng_count >= 20) && guard < 3000) begin
         run_random(1);
         guard++;
      end
      drain();
      c.turn_ticks    = 20'd3;
      c.forward_ticks = 20'd3;
      set_config(c);
      run_random(40);
      drain();

      c.echo_timeout_ticks = '1;
      c.turn_ticks         = 20'd10;
      c.forward_ticks      = 20'd10;
      set_config(c);
      run_random(40);
      drain();

      repeat (8) begin
         c.echo_timeout_ticks = TIMEOUT_W'($urandom_range(1, 60));
         c.near_limit         = LIMIT_W'($urandom_range(0, 10) * CM_SCALE);
         c.turn_limit         = LIMIT_W'(c.near_limit + $urandom_range(0, 10) * CM_SCALE);
         c.far_limit          = LIMIT_W'(c.turn_limit + $urandom_range(0, 15) * CM_SCALE);
         if ($urandom_range(1)) c.near_limit = LIMIT_W'(c.near_limit + $urandom_range(1, 16));
         if ($urandom_range(1)) c.far_limit  = LIMIT_W'(c.far_limit + $urandom_range(1, 16));
         c.turn_ticks    = COUNT_W'($urandom_range(0, 30));
         c.forward_ticks = COUNT_W'($urandom_range(0, 30));
         c.drive_duty    = DUTY_W'($urandom_range(0, 1023));
         noise_pct       = ($urandom_range(3) == 0) ? 40 : 8;
         set_config(c);
         run_random(55);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("** ultrasonic_obstacle_avoid_ctrl_top: PASSED **");
      end else begin
         $display("** ultrasonic_obstacle_avoid_ctrl_top: FAILED **");
      end
      $finish;
   end

endmodule
